>>> rtl/modexp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared types and constants for the modular exponentiation unit.
// ----------------------------------------------------------------------------
package modexp_pkg;

    // configuration register indexes
    localparam logic CFG_MODULUS  = 1'b0;
    localparam logic CFG_EXPONENT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_MUL,
        ST_DONE
    } modexp_state_t;

endpackage : modexp_pkg
`default_nettype wire

>>> rtl/modular_exponentiation_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation_unit
// message = ciphertext ^ exponent mod modulus, right-to-left square-and-
// multiply with bit-serial interleaved modular reduction.
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------
//   input    | start & !busy       | ciphertext, last_in
//   result   | done (1-cycle)      | message, last_out
//   config   | cfg_write           | cfg_index, cfg_data
//
// One word at a time: operand reduction, then a check and a multiply pass
// for each exponent bit up to the highest set one, then the result; a
// modulus below 2 goes straight to the result. The two modular products
// of a step share the multiplier bit stream, one bit per cycle.
// Reset returns to idle with modulus 2 and exponent 1. The result strobe
// cannot be stalled; busy stays high until the result cycle is over.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit #(
    parameter int WIDTH = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [WIDTH-1:0] ciphertext,
    input  wire logic             last_in,
    input  wire logic             cfg_write,
    input  wire logic             cfg_index,
    input  wire logic [WIDTH-1:0] cfg_data,
    output logic                  done,
    output logic      [WIDTH-1:0] message,
    output logic                  last_out
);
    import modexp_pkg::*;

    localparam int CNT_W = $clog2(WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    // One step of MSB-first multiply: (2r + bit*a) mod n, with r, a < n.
    // The sum stays below 3n, so one of two subtractions finishes it.
    function automatic logic [WIDTH-1:0] mod_step(
        input logic [WIDTH-1:0] r,
        input logic [WIDTH-1:0] a,
        input logic             b,
        input logic [WIDTH-1:0] n
    );
        logic [WIDTH+1:0] t;
        logic [WIDTH+1:0] n1;
        logic [WIDTH+1:0] n2;
        t  = {1'b0, r, 1'b0} + (b ? {2'b00, a} : '0);
        n1 = {2'b00, n};
        n2 = {1'b0, n, 1'b0};
        if (t >= n2)
            t = t - n2;
        else if (t >= n1)
            t = t - n1;
        return t[WIDTH-1:0];
    endfunction

    modexp_state_t    state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] modulus_reg, exponent_reg;

    logic [WIDTH-1:0] shift_reg, shift_next;   // ciphertext, then multiplier bits
    logic [WIDTH-1:0] exp_reg, exp_next;       // remaining exponent bits
    logic [WIDTH-1:0] base_reg, base_next;
    logic [WIDTH-1:0] m_reg, m_next;
    logic [WIDTH-1:0] rm_reg, rm_next;         // partial m * base
    logic [WIDTH-1:0] rb_reg, rb_next;         // partial base * base
    logic             last_reg, last_next;

    logic             in_bit;
    logic [WIDTH-1:0] rm_step;
    logic [WIDTH-1:0] rb_step;

    assign in_bit  = shift_reg[WIDTH-1];
    // during reduction rb doubles as the remainder with a = 1
    assign rb_step = mod_step(rb_reg,
                              (state_reg == ST_REDUCE) ? WIDTH'(1) : base_reg,
                              in_bit, modulus_reg);
    assign rm_step = mod_step(rm_reg, m_reg, in_bit, modulus_reg);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        exp_next   = exp_reg;
        base_next  = base_reg;
        m_next     = m_reg;
        rm_next    = rm_reg;
        rb_next    = rb_reg;
        last_next  = last_reg;
        busy       = (state_reg != ST_IDLE);
        done       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    shift_next = ciphertext;
                    exp_next   = exponent_reg;
                    last_next  = last_in;
                    rb_next    = '0;
                    cnt_next   = '0;
                    m_next     = '0;
                    if (modulus_reg < WIDTH'(2))
                        state_next = ST_DONE;
                    else
                        state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                rb_next    = rb_step;
                shift_next = {shift_reg[WIDTH-2:0], 1'b0};
                cnt_next   = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    base_next  = rb_step;
                    m_next     = WIDTH'(1);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (exp_reg == '0)
                    state_next = ST_DONE;
                else
                begin
                    shift_next = base_reg;
                    rm_next    = '0;
                    rb_next    = '0;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                rm_next    = rm_step;
                rb_next    = rb_step;
                shift_next = {shift_reg[WIDTH-2:0], 1'b0};
                cnt_next   = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    if (exp_reg[0])
                        m_next = rm_step;
                    base_next  = rb_step;
                    exp_next   = {1'b0, exp_reg[WIDTH-1:1]};
                    state_next = ST_CHECK;
                end
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign message  = m_reg;
    assign last_out = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            modulus_reg  <= WIDTH'(2);
            exponent_reg <= WIDTH'(1);
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_MODULUS:  modulus_reg  <= cfg_data;
                    CFG_EXPONENT: exponent_reg <= cfg_data;
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        exp_reg   <= exp_next;
        base_reg  <= base_next;
        m_reg     <= m_next;
        rm_reg    <= rm_next;
        rb_reg    <= rb_next;
        last_reg  <= last_next;
    end

endmodule : modular_exponentiation_unit
`default_nettype wire
